FILE: design/kmeans_2d_clustering_defines.svh
// ----------------------------------------------------------------------------
// kmeans_2d_clustering_defines : assertion macros for the k-means block
// Each check has a live form and an empty form for synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KMEANS_2D_CLUSTERING_DEFINES_SVH
`define KMEANS_2D_CLUSTERING_DEFINES_SVH
`ifndef SYNTH
`define KMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmc: implication check failed");
`define KMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmc: next-cycle check failed");
`else
`define KMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg : shared types and constants
// Field widths, generator constants, register indexes and unit status.
// ----------------------------------------------------------------------------
`default_nettype none
package kmc_pkg;
    localparam int CLUSTERS = 16;
    localparam int CL_W     = 4;
    localparam int K_W      = 5;
    localparam int COORD_W  = 24;
    localparam int CNT_W    = 11;
    localparam int VAR_W    = 60;
    localparam int ITER_W   = 16;
    localparam int SEED_W   = 32;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIST_W   = 2 * COORD_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [MUL_W-1:0]  LCG_MUL = 33'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

FILE: design/kmc_ram.sv
// ----------------------------------------------------------------------------
// kmc_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/kmc_mul.sv
// ----------------------------------------------------------------------------
// kmc_mul : shared signed multiplier
// Registered product; serves the generator step and the squared distances.
// ----------------------------------------------------------------------------
`default_nettype none
module kmc_mul import kmc_pkg::*; (
    input  wire                      i_clk,
    input  wire  signed [MUL_W-1:0]  i_a,
    input  wire  signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

FILE: design/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div : serial unsigned divider
// Restoring division, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module kmc_div import kmc_pkg::*; #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 11
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [NUM_W-1:0]  i_num,
    input  wire  [DEN_W-1:0]  i_den,
    output t_div_stat         o_stat,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[DEN_W-1:0];
                end
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
endmodule
`default_nettype wire

FILE: design/kmeans_2d_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_2d_clustering : Lloyd k-means over 2D Q12.12 points
// Point store, sequencer, shared multiplier and serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one point per beat; a point
//   is taken every cycle while loading. Points beyond MAX_POINTS are dropped.
//   A beat with i_last_point set starts the run; o_in_ready then stays low.
//   Seeding gives each point a pseudo-random first label, using the multiplier
//   for the generator step and the 34-step divider for the label. Each iteration
//   sums the points per cluster, forms the means with the serial divider
//   (skipping empty clusters) and assigns each point to its nearest centroid,
//   where the single multiplier forms dx^2 and dy^2 one after the other.
//   A closing pass counts members and sums squared distances. Then K result
//   beats leave on o_out_valid/i_out_ready, one per cycle while the
//   receiver takes them; a stalled receiver holds the current beat. After the
//   last result the block returns to loading with an empty store.
//   Configuration writes (i_cfg_valid/o_cfg_ready) are always accepted.
//   Reset (synchronous, active low) empties the store and restores the
//   register defaults: one cluster, seed zero, limit 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmeans_2d_clustering_defines.svh"
module kmeans_2d_clustering import kmc_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [CFG_DAT_W-1:0]        i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  signed [COORD_W-1:0]   i_point_x,
    input  wire  signed [COORD_W-1:0]   i_point_y,
    input  wire                         i_last_point,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [CL_W-1:0]             o_cluster_index,
    output logic signed [COORD_W-1:0]   o_centroid_x,
    output logic signed [COORD_W-1:0]   o_centroid_y,
    output logic [CNT_W-1:0]            o_member_count,
    output logic [VAR_W-1:0]            o_sum_sq_variance,
    output logic [ITER_W-1:0]           o_iterations_used,
    output logic                        o_converged,
    output logic                        o_last_result
);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PW    = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = COORD_W + AW;
    localparam int DVW   = (PW > K_W) ? PW : K_W;
    localparam int DX_W  = COORD_W + 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_ITER = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ASN  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [2:0] PH_S0 = 3'd0;
    localparam logic [2:0] PH_S1 = 3'd1;
    localparam logic [2:0] PH_S2 = 3'd2;
    localparam logic [2:0] PH_S3 = 3'd3;
    localparam logic [2:0] PH_S4 = 3'd4;
    localparam logic [2:0] PH_S5 = 3'd5;

    logic [2:0]                r_state;
    logic [2:0]                r_ph;
    logic [PW-1:0]             r_count;
    logic [PW-1:0]             r_idx;
    logic [CL_W-1:0]           r_j;
    logic [K_W-1:0]            r_k;
    logic [ITER_W-1:0]         r_limit;
    logic [K_W-1:0]            r_cfg_k;
    logic [SEED_W-1:0]         r_cfg_seed;
    logic [ITER_W-1:0]         r_cfg_limit;
    logic [SEED_W-1:0]         r_gen;
    logic [ITER_W-1:0]         r_iter;
    logic                      r_conv;
    logic                      r_changed;
    logic signed [COORD_W-1:0] r_cx [CLUSTERS];
    logic signed [COORD_W-1:0] r_cy [CLUSTERS];
    logic signed [SUM_W-1:0]   r_sx [CLUSTERS];
    logic signed [SUM_W-1:0]   r_sy [CLUSTERS];
    logic [PW-1:0]             r_cnt [CLUSTERS];
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [CL_W-1:0]           r_lab;
    logic [DIST_W-1:0]         r_acc;
    logic [DIST_W-1:0]         r_bd;
    logic [CL_W-1:0]           r_best;
    logic [VAR_W-1:0]          r_var;
    logic                      r_ov;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic                      w_pt_we;
    logic                      w_lab_we;
    logic [CL_W-1:0]           w_lab_wdata;
    logic [COORD_W-1:0]        w_rx;
    logic [COORD_W-1:0]        w_ry;
    logic [CL_W-1:0]           w_rl;
    logic [CL_W-1:0]           w_ci;
    logic                      w_idx_last;
    logic [K_W-1:0]            w_j_ext;
    logic                      w_j_last;
    logic signed [DX_W-1:0]    w_dx;
    logic signed [DX_W-1:0]    w_dy;
    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic [SEED_W-1:0]         w_gen;
    logic [DIST_W-1:0]         w_d;
    logic                      w_sx_neg;
    logic                      w_sy_neg;
    logic [SUM_W-1:0]          w_sx_mag;
    logic [SUM_W-1:0]          w_sy_mag;
    logic                      w_dv_start;
    logic [SUM_W-1:0]          w_dv_num;
    logic [DVW-1:0]            w_dv_den;
    t_div_stat                 w_dv_stat;
    logic [SUM_W-1:0]          w_dv_quo;
    logic [DVW-1:0]            w_dv_rem;
    logic [SUM_W-1:0]          w_qs;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_out_acc   = r_ov & i_out_ready;
    assign w_pt_we     = w_in_acc && (r_count < PW'(MAX_POINTS));

    assign w_idx_last = (r_idx + PW'(1)) == r_count;
    assign w_j_ext    = {1'b0, r_j};
    assign w_j_last   = (w_j_ext + K_W'(1)) == r_k;
    assign w_ci       = (r_state == S_ACC) ? w_rl : r_j;

    assign w_dx = DX_W'(r_px) - DX_W'(r_cx[r_j]);
    assign w_dy = DX_W'(r_py) - DX_W'(r_cy[r_j]);
    assign w_ma = (r_state == S_SEED) ? MUL_W'({1'b0, r_gen})
                : (r_ph == PH_S3) ? MUL_W'(w_dy) : MUL_W'(w_dx);
    assign w_mb = (r_state == S_SEED) ? LCG_MUL : w_ma;
    assign w_gen = w_prod[SEED_W-1:0] + LCG_ADD;
    assign w_d   = r_acc + w_prod[DIST_W-1:0];

    assign w_sx_neg = r_sx[r_j][SUM_W-1];
    assign w_sy_neg = r_sy[r_j][SUM_W-1];
    assign w_sx_mag = w_sx_neg ? SUM_W'(-r_sx[r_j]) : SUM_W'(r_sx[r_j]);
    assign w_sy_mag = w_sy_neg ? SUM_W'(-r_sy[r_j]) : SUM_W'(r_sy[r_j]);
    assign w_qs     = SUM_W'(-w_dv_quo);

    always_comb begin
        w_dv_start = 1'b0;
        w_dv_num   = w_sy_mag;
        w_dv_den   = DVW'(r_cnt[r_j]);
        if (r_state == S_SEED) begin
            w_dv_start = (r_ph == PH_S1);
            w_dv_num   = SUM_W'(w_gen[30:16]);
            w_dv_den   = DVW'(r_k);
        end else if (r_state == S_DIV) begin
            if (r_ph == PH_S0) begin
                w_dv_start = (r_cnt[r_j] != '0);
                w_dv_num   = w_sx_mag;
            end else if (r_ph == PH_S1) begin
                w_dv_start = w_dv_stat.done;
            end
        end
    end

    assign w_lab_we = ((r_state == S_SEED) && (r_ph == PH_S2) && w_dv_stat.done)
                   || ((r_state == S_ASN) && (r_ph == PH_S5) && (r_best != r_lab));
    assign w_lab_wdata = (r_state == S_SEED) ? w_dv_rem[CL_W-1:0] : r_best;

    kmc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_point_x),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rx)
    );

    kmc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_point_y),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_ry)
    );

    kmc_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_ram_lab (
        .i_clk   (i_clk),
        .i_we    (w_lab_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_lab_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rl)
    );

    kmc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    kmc_div #(.NUM_W(SUM_W), .DEN_W(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .o_stat  (w_dv_stat),
        .o_quo   (w_dv_quo),
        .o_rem   (w_dv_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ph        <= PH_S0;
            r_count     <= '0;
            r_idx       <= '0;
            r_j         <= '0;
            r_k         <= K_W'(1);
            r_limit     <= ITER_W'(1);
            r_cfg_k     <= K_W'(1);
            r_cfg_seed  <= '0;
            r_cfg_limit <= ITER_W'(255);
            r_gen       <= '0;
            r_iter      <= '0;
            r_conv      <= 1'b0;
            r_changed   <= 1'b0;
            r_var       <= '0;
            r_ov        <= 1'b0;
            for (int c = 0; c < CLUSTERS; c++) begin
                r_cx[c]  <= '0;
                r_cy[c]  <= '0;
                r_sx[c]  <= '0;
                r_sy[c]  <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLUSTERS: r_cfg_k     <= i_cfg_data[K_W-1:0];
                    CFG_SEED:     r_cfg_seed  <= i_cfg_data[SEED_W-1:0];
                    CFG_LIMIT:    r_cfg_limit <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_pt_we) begin
                        r_count <= r_count + PW'(1);
                    end
                    if (w_in_acc && i_last_point) begin
                        priority if (r_cfg_k == '0) begin
                            r_k <= K_W'(1);
                        end else if (r_cfg_k > K_W'(CLUSTERS)) begin
                            r_k <= K_W'(CLUSTERS);
                        end else begin
                            r_k <= r_cfg_k;
                        end
                        r_limit <= (r_cfg_limit == '0) ? ITER_W'(1) : r_cfg_limit;
                        r_gen   <= r_cfg_seed;
                        r_iter  <= '0;
                        r_conv  <= 1'b0;
                        r_idx   <= '0;
                        r_ph    <= PH_S0;
                        for (int c = 0; c < CLUSTERS; c++) begin
                            r_cx[c] <= '0;
                            r_cy[c] <= '0;
                        end
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (r_ph == PH_S0) begin
                        r_ph <= PH_S1;
                    end else if (r_ph == PH_S1) begin
                        r_gen <= w_gen;
                        r_ph  <= PH_S2;
                    end else if (w_dv_stat.done) begin
                        r_idx <= r_idx + PW'(1);
                        r_ph  <= PH_S0;
                        if (w_idx_last) begin
                            r_state <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    r_iter    <= r_iter + ITER_W'(1);
                    r_changed <= 1'b0;
                    r_idx     <= '0;
                    r_ph      <= PH_S0;
                    for (int c = 0; c < CLUSTERS; c++) begin
                        r_sx[c]  <= '0;
                        r_sy[c]  <= '0;
                        r_cnt[c] <= '0;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ph == PH_S0) begin
                        r_ph <= PH_S1;
                    end else begin
                        r_sx[w_ci]  <= r_sx[w_ci] + SUM_W'(signed'(w_rx));
                        r_sy[w_ci]  <= r_sy[w_ci] + SUM_W'(signed'(w_ry));
                        r_cnt[w_ci] <= r_cnt[w_ci] + PW'(1);
                        r_idx       <= r_idx + PW'(1);
                        r_ph        <= PH_S0;
                        if (w_idx_last) begin
                            r_j     <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_ph == PH_S0) begin
                        if (r_cnt[r_j] != '0) begin
                            r_ph <= PH_S1;
                        end else if (w_j_last) begin
                            r_idx   <= '0;
                            r_state <= S_ASN;
                        end else begin
                            r_j <= r_j + CL_W'(1);
                        end
                    end else if (w_dv_stat.done) begin
                        if (r_ph == PH_S1) begin
                            r_cx[r_j] <= w_sx_neg ? w_qs[COORD_W-1:0]
                                                  : w_dv_quo[COORD_W-1:0];
                            r_ph      <= PH_S2;
                        end else begin
                            r_cy[r_j] <= w_sy_neg ? w_qs[COORD_W-1:0]
                                                  : w_dv_quo[COORD_W-1:0];
                            r_ph      <= PH_S0;
                            if (w_j_last) begin
                                r_idx   <= '0;
                                r_state <= S_ASN;
                            end else begin
                                r_j <= r_j + CL_W'(1);
                            end
                        end
                    end
                end
                S_ASN, S_FIN: begin
                    unique case (r_ph)
                        PH_S0: r_ph <= PH_S1;
                        PH_S1: begin
                            r_px  <= w_rx;
                            r_py  <= w_ry;
                            r_lab <= w_rl;
                            r_j   <= (r_state == S_FIN) ? w_rl : '0;
                            r_ph  <= PH_S2;
                        end
                        PH_S2: r_ph <= PH_S3;
                        PH_S3: begin
                            r_acc <= w_prod[DIST_W-1:0];
                            r_ph  <= PH_S4;
                        end
                        PH_S4: begin
                            if (r_state == S_FIN) begin
                                r_var    <= r_var + VAR_W'(w_d);
                                r_cnt[r_j] <= r_cnt[r_j] + PW'(1);
                                r_idx    <= r_idx + PW'(1);
                                r_ph     <= PH_S0;
                                if (w_idx_last) begin
                                    r_j     <= '0;
                                    r_ov    <= 1'b1;
                                    r_state <= S_OUT;
                                end
                            end else begin
                                if ((r_j == '0) || (w_d < r_bd)) begin
                                    r_bd   <= w_d;
                                    r_best <= r_j;
                                end
                                if (w_j_last) begin
                                    r_ph <= PH_S5;
                                end else begin
                                    r_j  <= r_j + CL_W'(1);
                                    r_ph <= PH_S2;
                                end
                            end
                        end
                        PH_S5: begin
                            r_idx <= r_idx + PW'(1);
                            r_ph  <= PH_S0;
                            if (r_best != r_lab) begin
                                r_changed <= 1'b1;
                            end
                            if (w_idx_last) begin
                                if (!r_changed && (r_best == r_lab)) begin
                                    r_conv <= 1'b1;
                                end
                                if ((!r_changed && (r_best == r_lab))
                                        || (r_iter >= r_limit)) begin
                                    r_idx <= '0;
                                    r_var <= '0;
                                    for (int c = 0; c < CLUSTERS; c++) begin
                                        r_cnt[c] <= '0;
                                    end
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_ITER;
                                end
                            end
                        end
                        default: r_ph <= PH_S0;
                    endcase
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (w_j_last) begin
                            r_ov    <= 1'b0;
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_j <= r_j + CL_W'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid       = r_ov;
    assign o_cluster_index   = r_j;
    assign o_centroid_x      = r_cx[r_j];
    assign o_centroid_y      = r_cy[r_j];
    assign o_member_count    = CNT_W'(r_cnt[r_j]);
    assign o_sum_sq_variance = r_var;
    assign o_iterations_used = r_iter;
    assign o_converged       = r_conv;
    assign o_last_result     = w_j_last;

    `KMC_ASSERT_IMP(a_load_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `KMC_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= PW'(MAX_POINTS))
    `KMC_ASSERT_IMP(a_out_index, i_clk, i_rst_n, o_out_valid, w_j_ext < r_k)
    `KMC_ASSERT_IMP(a_k_range, i_clk, i_rst_n, 1'b1,
                    (r_k != '0) && (r_k <= K_W'(CLUSTERS)))
    `KMC_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, (r_state == S_DIV) && (r_ph != PH_S0),
                    w_dv_stat.busy || w_dv_stat.done)
endmodule
`default_nettype wire
